@@ sv/rcu_pkg.sv @@
package rcu_pkg;

   localparam int ACC_W          = 64;
   localparam int RADIX_W        = 6;
   localparam int CHAR_W         = 8;
   localparam int CODE_W         = 7;
   localparam int STAT_W         = 2;
   localparam int DIGIT_W        = 6;
   localparam int PROD_W         = ACC_W + RADIX_W;
   localparam int SUM_W          = PROD_W + 1;

   localparam int MAX_IN_CHARS   = 20;
   localparam int CHAR_CNT_W     = $clog2(MAX_IN_CHARS + 1);
   localparam int MAX_OUT_DIGITS = 64;
   localparam int STORE_DEPTH    = 64;
   localparam int ADDR_W         = $clog2(STORE_DEPTH);
   localparam int DCNT_W         = $clog2(STORE_DEPTH + 1);

   localparam int DIV_BITS       = 4;
   localparam int DIV_STEPS      = ACC_W / DIV_BITS;
   localparam int STEP_W         = $clog2(DIV_STEPS);

   localparam int CSR_IDX_W      = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIX_IN  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIX_OUT = 1'd1;

   localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_IN_RST  = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_OUT_RST = 6'd2;

   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_BAD_DIGIT = 2'd1;
   localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd2;

   localparam logic [DIGIT_W-1:0] DIGIT_NONE = 6'd36;

   typedef enum logic [3:0] {
      S_IDLE,
      S_UPDATE,
      S_ERR_OUT,
      S_DIV_INIT,
      S_DIV_RUN,
      S_DIV_STORE,
      S_OVF_OUT,
      S_EMIT_RD,
      S_EMIT_OUT
   } state_type;

   typedef struct packed {
      logic capture;
      logic update;
      logic div_init;
      logic div_step;
      logic div_store;
      logic load_err;
      logic load_ovf;
      logic rd_issue;
      logic load_digit;
   } cmd_type;

   typedef struct packed {
      logic last_char;
      logic err_after;
      logic div_last;
      logic quot_zero;
      logic digits_full;
      logic out_free;
      logic rd_zero;
   } stat_type;

   function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
      logic [RADIX_W-1:0] res;
      if (r < RADIX_MIN) begin
         res = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         res = RADIX_MAX;
      end else begin
         res = r;
      end
      return res;
   endfunction

   // Value of an ASCII digit, or DIGIT_NONE for anything outside 0-9 and A-Z.
   function automatic logic [DIGIT_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] t;
      logic [DIGIT_W-1:0] res;
      if (c >= 8'h30 && c <= 8'h39) begin
         t   = c - 8'h30;
         res = t[DIGIT_W-1:0];
      end else if (c >= 8'h41 && c <= 8'h5A) begin
         t   = c - 8'h37;
         res = t[DIGIT_W-1:0];
      end else begin
         res = DIGIT_NONE;
      end
      return res;
   endfunction

   function automatic logic [CODE_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
      logic [CODE_W-1:0] res;
      if (d < 6'd10) begin
         res = 7'h30 + {1'b0, d};
      end else begin
         res = 7'h37 + {1'b0, d};
      end
      return res;
   endfunction

endpackage

@@ sv/radix_converter_unit.sv @@
// Radix converter: ASCII numeral in radix_in (2..36) to ASCII numeral in radix_out.
// Request channel: one character word per handshake (req_char_code, req_last_char),
// most significant first. A word is taken when req_valid is high and req_stall low.
// For each character the accumulator times the radix is
// registered, then the digit is added and checked for overflow.
// On the last character the value is converted by a restoring divider that yields
// four quotient bits a cycle; digits go to a 64-entry store, then each is read back
// most significant first.
// Synchronous reset sets radix_in to 10, radix_out to 2 and clears the run state.
// Response channel: rsp_digit_code, rsp_status (0 ok, 1 bad digit, 2 overflow),
// rsp_last_result, taken when rsp_valid is high and rsp_stall low. An error run
// gives one word with code zero. While the receiver stalls, the output word holds
// and conversion waits before loading the next one.
// Registers are written through csr_wr_en/csr_index/csr_wdata; the user must write
// them only while the block is idle, since the block itself does not enforce it.
module radix_converter_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [rcu_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rcu_pkg::RADIX_W-1:0]   csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [rcu_pkg::CHAR_W-1:0]    req_char_code,
   input  logic                          req_last_char,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rcu_pkg::CODE_W-1:0]    rsp_digit_code,
   output logic [rcu_pkg::STAT_W-1:0]    rsp_status,
   output logic                          rsp_last_result
);

   rcu_pkg::cmd_type  cmd;
   rcu_pkg::stat_type stat;

   rcu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   rcu_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_char_code   (req_char_code),
      .req_last_char   (req_last_char),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_digit_code  (rsp_digit_code),
      .rsp_status      (rsp_status),
      .rsp_last_result (rsp_last_result),
      .cmd             (cmd),
      .stat            (stat)
   );

endmodule

@@ sv/rcu_ram.sv @@
module rcu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/rcu_ctrl.sv @@
module rcu_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rcu_pkg::stat_type stat,
   output rcu_pkg::cmd_type  cmd
);

   rcu_pkg::state_type state_ff;
   rcu_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rcu_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rcu_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = rcu_pkg::S_UPDATE;
            end
         end
         rcu_pkg::S_UPDATE: begin
            priority if (!stat.last_char) begin
               state_in = rcu_pkg::S_IDLE;
            end else if (stat.err_after) begin
               state_in = rcu_pkg::S_ERR_OUT;
            end else begin
               state_in = rcu_pkg::S_DIV_INIT;
            end
         end
         rcu_pkg::S_ERR_OUT: begin
            if (stat.out_free) begin
               state_in = rcu_pkg::S_IDLE;
            end
         end
         rcu_pkg::S_DIV_INIT: begin
            state_in = rcu_pkg::S_DIV_RUN;
         end
         rcu_pkg::S_DIV_RUN: begin
            if (stat.div_last) begin
               state_in = rcu_pkg::S_DIV_STORE;
            end
         end
         rcu_pkg::S_DIV_STORE: begin
            priority if (stat.digits_full) begin
               state_in = rcu_pkg::S_OVF_OUT;
            end else if (stat.quot_zero) begin
               state_in = rcu_pkg::S_EMIT_RD;
            end else begin
               state_in = rcu_pkg::S_DIV_RUN;
            end
         end
         rcu_pkg::S_OVF_OUT: begin
            if (stat.out_free) begin
               state_in = rcu_pkg::S_IDLE;
            end
         end
         rcu_pkg::S_EMIT_RD: begin
            state_in = rcu_pkg::S_EMIT_OUT;
         end
         rcu_pkg::S_EMIT_OUT: begin
            if (stat.out_free) begin
               state_in = stat.rd_zero ? rcu_pkg::S_IDLE : rcu_pkg::S_EMIT_RD;
            end
         end
         default: begin
            state_in = rcu_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         rcu_pkg::S_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         rcu_pkg::S_UPDATE:    cmd.update     = 1'b1;
         rcu_pkg::S_ERR_OUT:   cmd.load_err   = stat.out_free;
         rcu_pkg::S_DIV_INIT:  cmd.div_init   = 1'b1;
         rcu_pkg::S_DIV_RUN:   cmd.div_step   = 1'b1;
         rcu_pkg::S_DIV_STORE: cmd.div_store  = !stat.digits_full;
         rcu_pkg::S_OVF_OUT:   cmd.load_ovf   = stat.out_free;
         rcu_pkg::S_EMIT_RD:   cmd.rd_issue   = 1'b1;
         rcu_pkg::S_EMIT_OUT:  cmd.load_digit = stat.out_free;
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ sv/rcu_dpath.sv @@
module rcu_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [rcu_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rcu_pkg::RADIX_W-1:0]      csr_wdata,
   input  logic [rcu_pkg::CHAR_W-1:0]       req_char_code,
   input  logic                             req_last_char,
   input  logic                             rsp_stall,
   output logic                             rsp_valid,
   output logic [rcu_pkg::CODE_W-1:0]       rsp_digit_code,
   output logic [rcu_pkg::STAT_W-1:0]       rsp_status,
   output logic                             rsp_last_result,
   input  rcu_pkg::cmd_type                 cmd,
   output rcu_pkg::stat_type                stat
);

   logic [rcu_pkg::RADIX_W-1:0]    radix_in_ff;
   logic [rcu_pkg::RADIX_W-1:0]    radix_out_ff;
   logic [rcu_pkg::RADIX_W-1:0]    rin_c;
   logic [rcu_pkg::RADIX_W-1:0]    rout_c;

   logic [rcu_pkg::ACC_W-1:0]      accum_ff;
   logic [rcu_pkg::ACC_W-1:0]      accum_in;
   logic [rcu_pkg::STAT_W-1:0]     err_ff;
   logic [rcu_pkg::STAT_W-1:0]     err_in;
   logic [rcu_pkg::CHAR_CNT_W-1:0] char_cnt_ff;
   logic [rcu_pkg::CHAR_CNT_W-1:0] char_cnt_in;

   logic [rcu_pkg::PROD_W-1:0]     prod_ff;
   logic [rcu_pkg::DIGIT_W-1:0]    dval_ff;
   logic                           last_chr_ff;
   logic [rcu_pkg::SUM_W-1:0]      sum;

   logic [rcu_pkg::ACC_W-1:0]      quot_ff;
   logic [rcu_pkg::ACC_W-1:0]      quot_in;
   logic [rcu_pkg::RADIX_W-1:0]    rem_ff;
   logic [rcu_pkg::RADIX_W-1:0]    rem_in;
   logic [rcu_pkg::STEP_W-1:0]     step_ff;

   logic [rcu_pkg::DCNT_W-1:0]     digit_cnt_ff;
   logic [rcu_pkg::ADDR_W-1:0]     rd_ptr_ff;
   logic [rcu_pkg::DIGIT_W-1:0]    rd_data;

   logic                           rsp_valid_ff;
   logic [rcu_pkg::CODE_W-1:0]     rsp_code_ff;
   logic [rcu_pkg::STAT_W-1:0]     rsp_status_ff;
   logic                           rsp_last_ff;

   assign rin_c  = rcu_pkg::clamp_radix(radix_in_ff);
   assign rout_c = rcu_pkg::clamp_radix(radix_out_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_in_ff  <= rcu_pkg::RADIX_IN_RST;
         radix_out_ff <= rcu_pkg::RADIX_OUT_RST;
      end else if (csr_wr_en) begin
         if (csr_index == rcu_pkg::CSR_RADIX_IN) begin
            radix_in_ff <= csr_wdata;
         end
         if (csr_index == rcu_pkg::CSR_RADIX_OUT) begin
            radix_out_ff <= csr_wdata;
         end
      end
   end

   // Character step: the product is registered on capture, the add and the
   // overflow check follow in the next cycle.
   assign sum = {1'b0, prod_ff} + rcu_pkg::SUM_W'(dval_ff);

   always_comb begin
      accum_in    = accum_ff;
      err_in      = err_ff;
      char_cnt_in = char_cnt_ff;
      if (char_cnt_ff >= rcu_pkg::CHAR_CNT_W'(rcu_pkg::MAX_IN_CHARS)) begin
         if (err_ff == rcu_pkg::ST_OK) begin
            err_in = rcu_pkg::ST_BAD_DIGIT;
         end
      end else begin
         char_cnt_in = char_cnt_ff + 1'b1;
         if (err_ff == rcu_pkg::ST_OK) begin
            priority if (dval_ff >= rin_c) begin
               err_in = rcu_pkg::ST_BAD_DIGIT;
            end else if (sum[rcu_pkg::SUM_W-1:rcu_pkg::ACC_W] != '0) begin
               err_in = rcu_pkg::ST_OVERFLOW;
            end else begin
               accum_in = sum[rcu_pkg::ACC_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         prod_ff     <= rcu_pkg::PROD_W'(accum_ff) * rcu_pkg::PROD_W'(rin_c);
         dval_ff     <= rcu_pkg::digit_value(req_char_code);
         last_chr_ff <= req_last_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff    <= '0;
         err_ff      <= rcu_pkg::ST_OK;
         char_cnt_ff <= '0;
      end else if (cmd.update) begin
         accum_ff    <= accum_in;
         err_ff      <= err_in;
         char_cnt_ff <= char_cnt_in;
      end else if (cmd.div_init || cmd.load_err) begin
         accum_ff    <= '0;
         err_ff      <= rcu_pkg::ST_OK;
         char_cnt_ff <= '0;
      end
   end

   // Restoring division, DIV_BITS quotient bits per cycle, MSB first.
   always_comb begin
      logic [rcu_pkg::RADIX_W:0] r;
      logic [rcu_pkg::ACC_W-1:0] q;
      r = {1'b0, rem_ff};
      q = quot_ff;
      for (int i = 0; i < rcu_pkg::DIV_BITS; i++) begin
         r = {r[rcu_pkg::RADIX_W-1:0], q[rcu_pkg::ACC_W-1]};
         q = {q[rcu_pkg::ACC_W-2:0], 1'b0};
         if (r >= {1'b0, rout_c}) begin
            r    = r - {1'b0, rout_c};
            q[0] = 1'b1;
         end
      end
      rem_in  = r[rcu_pkg::RADIX_W-1:0];
      quot_in = q;
   end

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         quot_ff <= accum_ff;
         rem_ff  <= '0;
      end else if (cmd.div_step) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end else if (cmd.div_store) begin
         rem_ff  <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         digit_cnt_ff <= '0;
      end else begin
         if (cmd.div_init || cmd.div_store) begin
            step_ff <= '0;
         end else if (cmd.div_step) begin
            step_ff <= step_ff + 1'b1;
         end
         priority if (cmd.div_init || cmd.load_ovf) begin
            digit_cnt_ff <= '0;
         end else if (cmd.div_store) begin
            digit_cnt_ff <= digit_cnt_ff + 1'b1;
         end else begin
            digit_cnt_ff <= digit_cnt_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_store) begin
         rd_ptr_ff <= digit_cnt_ff[rcu_pkg::ADDR_W-1:0];
      end else if (cmd.load_digit) begin
         rd_ptr_ff <= rd_ptr_ff - 1'b1;
      end
   end

   rcu_ram #(
      .WIDTH (rcu_pkg::DIGIT_W),
      .DEPTH (rcu_pkg::STORE_DEPTH)
   ) u_digit_store (
      .clock   (clock),
      .wr_en   (cmd.div_store),
      .wr_addr (digit_cnt_ff[rcu_pkg::ADDR_W-1:0]),
      .wr_data (rem_ff),
      .rd_en   (cmd.rd_issue),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   // Output word register; a new word loads only when the slot is free.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_err || cmd.load_ovf || cmd.load_digit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      priority if (cmd.load_err) begin
         rsp_code_ff   <= '0;
         rsp_status_ff <= err_ff;
         rsp_last_ff   <= 1'b1;
      end else if (cmd.load_ovf) begin
         rsp_code_ff   <= '0;
         rsp_status_ff <= rcu_pkg::ST_OVERFLOW;
         rsp_last_ff   <= 1'b1;
      end else if (cmd.load_digit) begin
         rsp_code_ff   <= rcu_pkg::glyph(rd_data);
         rsp_status_ff <= rcu_pkg::ST_OK;
         rsp_last_ff   <= (rd_ptr_ff == '0);
      end else begin
         rsp_code_ff   <= rsp_code_ff;
         rsp_status_ff <= rsp_status_ff;
         rsp_last_ff   <= rsp_last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digit_code  = rsp_code_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last_result = rsp_last_ff;

   assign stat.last_char   = last_chr_ff;
   assign stat.err_after   = (err_in != rcu_pkg::ST_OK);
   assign stat.div_last    = (step_ff == rcu_pkg::STEP_W'(rcu_pkg::DIV_STEPS - 1));
   assign stat.quot_zero   = (quot_ff == '0);
   assign stat.digits_full =
      (digit_cnt_ff >= rcu_pkg::DCNT_W'(rcu_pkg::MAX_OUT_DIGITS));
   assign stat.out_free    = !rsp_valid_ff || !rsp_stall;
   assign stat.rd_zero     = (rd_ptr_ff == '0);

   a_err_code: assert property (@(posedge clock) disable iff (reset)
      err_ff == rcu_pkg::ST_OK || err_ff == rcu_pkg::ST_BAD_DIGIT ||
      err_ff == rcu_pkg::ST_OVERFLOW)
      else $error("error register holds an unused code");

   a_char_cnt: assert property (@(posedge clock) disable iff (reset)
      char_cnt_ff <= rcu_pkg::CHAR_CNT_W'(rcu_pkg::MAX_IN_CHARS))
      else $error("character count ran past its limit");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_err || cmd.load_ovf || cmd.load_digit) |-> (!rsp_valid_ff || !rsp_stall))
      else $error("output word overwritten while still held");

   a_run_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.div_init |=> (accum_ff == '0 && err_ff == rcu_pkg::ST_OK && char_cnt_ff == '0))
      else $error("run state not cleared at start of conversion");

endmodule
